// ===== hdl/ssc_pkg.sv =====
package ssc_pkg;

	localparam int BYTE_W  = 8;
	localparam int SPEED_W = 11;
	localparam int DUTY_W  = 16;
	localparam int MAG_W   = 10;
	localparam int SPD_SUM_W  = 20;
	localparam int DUTY_SUM_W = 24;
	localparam int BLEND_SHIFT = 8;

	// Kind of a received byte, taken from its top two bits.
	typedef enum logic [1:0] {
		KIND_SPEED    = 2'b00,
		KIND_MARK     = 2'b01,
		KIND_SERVO_HI = 2'b10,
		KIND_SERVO_LO = 2'b11
	} byte_kind_t;

	localparam logic [BYTE_W-1:0] FRAME_OPEN_MARK  = 8'h55;
	localparam logic [BYTE_W-1:0] FRAME_CLOSE_MARK = 8'h6A;

	localparam logic [MAG_W-1:0] SPEED_SCALE = 10'd22;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 11'sd682;
	localparam logic signed [SPEED_W:0]   SPEED_STEP_LIMIT = 12'sd500;

	localparam logic signed [SPD_SUM_W-1:0] SPD_WT_NEW = 20'sd77;
	localparam logic signed [SPD_SUM_W-1:0] SPD_WT_OLD = 20'sd179;
	localparam logic signed [SPD_SUM_W-1:0] SPD_ROUND  = 20'sd255;

	localparam logic [DUTY_SUM_W-1:0] DUTY_WT_NEW = 24'd205;
	localparam logic [DUTY_SUM_W-1:0] DUTY_WT_OLD = 24'd51;

	localparam logic [DUTY_W-1:0] CENTRE_RESET = 16'd2048;

	typedef struct packed {
		logic signed [SPEED_W-1:0] applied;
		logic signed [SPEED_W-1:0] pending;
	} speed_upd_t;

endpackage

// ===== hdl/speed_servo_command_decoder.sv =====
// Path: a request accepted into the input register moves on to the result register when the pipeline advances.
// Throughput: one request per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: arst_n clears the frame and pending decoder state, applied speed and duty to zero and
// sets servo_centre to 2048; both pipeline stages come up empty.
module speed_servo_command_decoder
	import ssc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // servo_centre
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [10:0] target_speed, [26:11] duty, rest zero
	output logic        m_axis_tuser   // frame_applied
);

	logic                      valid_s1;
	logic [BYTE_W-1:0]         byte_s1;
	logic                      valid_s2;
	logic signed [SPEED_W-1:0] speed_s2;
	logic [DUTY_W-1:0]         duty_s2;
	logic                      applied_s2;

	logic [DUTY_W-1:0]         centre_q;
	logic signed [SPEED_W-1:0] pending_speed_q;
	logic [DUTY_W-1:0]         pending_duty_q;
	logic [5:0]                high_part_q;
	logic                      high_seen_q;
	logic                      frame_open_q;
	logic signed [SPEED_W-1:0] applied_speed_q;
	logic [DUTY_W-1:0]         applied_duty_q;

	logic                      advance;
	logic                      step;
	byte_kind_t                kind;
	logic                      apply;
	logic [MAG_W-1:0]          mag;
	logic [10:0]               servo_val;

	logic signed [SPEED_W-1:0] pending_speed_d;
	logic [DUTY_W-1:0]         pending_duty_d;
	logic [5:0]                high_part_d;
	logic                      high_seen_d;
	logic                      frame_open_d;
	logic signed [SPEED_W-1:0] applied_speed_d;
	logic [DUTY_W-1:0]         applied_duty_d;

	speed_upd_t                speed_upd;
	logic [DUTY_W-1:0]         duty_blend;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = advance && valid_s1;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, duty_s2, speed_s2};
	assign m_axis_tuser  = applied_s2;

	ssc_speed_blend u_speed (
		.pending (pending_speed_q),
		.applied (applied_speed_q),
		.upd     (speed_upd)
	);

	ssc_duty_blend u_duty (
		.pending (pending_duty_q),
		.applied (applied_duty_q),
		.centre  (centre_q),
		.duty    (duty_blend)
	);

	always_comb begin
		kind      = byte_kind_t'(byte_s1[7:6]);
		apply     = 1'b0;
		mag       = MAG_W'(byte_s1[4:0]) * SPEED_SCALE;
		servo_val = {high_part_q[4:0], byte_s1[5:0]};

		pending_speed_d = pending_speed_q;
		pending_duty_d  = pending_duty_q;
		high_part_d     = high_part_q;
		high_seen_d     = high_seen_q;
		frame_open_d    = frame_open_q;
		applied_speed_d = applied_speed_q;
		applied_duty_d  = applied_duty_q;

		case (kind)
			KIND_SPEED: begin
				pending_speed_d = byte_s1[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			end
			KIND_MARK: begin
				if (byte_s1 == FRAME_OPEN_MARK) begin
					frame_open_d = 1'b1;
				end else if (byte_s1 == FRAME_CLOSE_MARK && frame_open_q) begin
					apply           = 1'b1;
					frame_open_d    = 1'b0;
					pending_speed_d = speed_upd.pending;
					applied_speed_d = speed_upd.applied;
					applied_duty_d  = duty_blend;
				end
			end
			KIND_SERVO_HI: begin
				high_part_d = byte_s1[5:0];
				high_seen_d = 1'b1;
			end
			KIND_SERVO_LO: begin
				// Bit 5 of the high half selects an offset below the centre.
				if (high_seen_q) begin
					pending_duty_d = high_part_q[5] ? centre_q - DUTY_W'(servo_val)
						: centre_q + DUTY_W'(servo_val);
				end
				high_seen_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= CENTRE_RESET;
		end else if (cfg_we) begin
			centre_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			pending_speed_q <= '0;
			pending_duty_q  <= '0;
			high_part_q     <= '0;
			high_seen_q     <= 1'b0;
			frame_open_q    <= 1'b0;
			applied_speed_q <= '0;
			applied_duty_q  <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pending_speed_q <= pending_speed_d;
				pending_duty_q  <= pending_duty_d;
				high_part_q     <= high_part_d;
				high_seen_q     <= high_seen_d;
				frame_open_q    <= frame_open_d;
				applied_speed_q <= applied_speed_d;
				applied_duty_q  <= applied_duty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			speed_s2   <= applied_speed_d;
			duty_s2    <= applied_duty_d;
			applied_s2 <= apply;
		end
	end

`ifndef NO_ASSERTIONS
	a_applied_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && applied_s2) |-> !frame_open_q)
		else $error("frame still open after an applied close mark");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (speed_s2 <= SPEED_MAX && speed_s2 >= -SPEED_MAX))
		else $error("applied speed out of range");

	a_targets_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !apply) |=> ($stable(applied_speed_q) && $stable(applied_duty_q)))
		else $error("applied targets changed without a frame close");

	a_low_half_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind == KIND_SERVO_LO) |=> !high_seen_q)
		else $error("high half still marked after a low half");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (speed_s2 == applied_speed_q && duty_s2 == applied_duty_q))
		else $error("result register disagrees with applied state");
`endif

endmodule

// ===== hdl/ssc_speed_blend.sv =====
module ssc_speed_blend
	import ssc_pkg::*;
(
	input  logic signed [SPEED_W-1:0] pending,
	input  logic signed [SPEED_W-1:0] applied,
	output speed_upd_t                upd
);

	logic                          direct;
	logic signed [SPEED_W:0]       diff;
	logic signed [SPEED_W:0]       clamped_w;
	logic signed [SPEED_W-1:0]     clamped;
	logic signed [SPD_SUM_W-1:0]   sum;
	logic signed [SPD_SUM_W-1:0]   sum_adj;
	logic signed [SPD_SUM_W-1:0]   shifted;

	always_comb begin
		// A zero command or a reversal is taken at once, without ramping.
		direct = (pending == '0) || (pending[SPEED_W-1] && !applied[SPEED_W-1] && applied != '0)
			|| (!pending[SPEED_W-1] && pending != '0 && applied[SPEED_W-1]);
		diff = (SPEED_W+1)'(pending) - (SPEED_W+1)'(applied);
		if (diff > SPEED_STEP_LIMIT) begin
			clamped_w = (SPEED_W+1)'(applied) + SPEED_STEP_LIMIT;
		end else if (diff < -SPEED_STEP_LIMIT) begin
			clamped_w = (SPEED_W+1)'(applied) - SPEED_STEP_LIMIT;
		end else begin
			clamped_w = (SPEED_W+1)'(pending);
		end
		clamped = clamped_w[SPEED_W-1:0];
		sum = SPD_WT_NEW * SPD_SUM_W'(clamped) + SPD_WT_OLD * SPD_SUM_W'(applied);
		// Bias negative sums so the arithmetic shift truncates toward zero.
		sum_adj = sum + (sum[SPD_SUM_W-1] ? SPD_ROUND : '0);
		shifted = sum_adj >>> BLEND_SHIFT;
		if (direct) begin
			upd.applied = pending;
			upd.pending = pending;
		end else begin
			upd.applied = shifted[SPEED_W-1:0];
			upd.pending = clamped;
		end
	end

endmodule

// ===== hdl/ssc_duty_blend.sv =====
module ssc_duty_blend
	import ssc_pkg::*;
(
	input  logic [DUTY_W-1:0] pending,
	input  logic [DUTY_W-1:0] applied,
	input  logic [DUTY_W-1:0] centre,
	output logic [DUTY_W-1:0] duty
);

	logic                  direct;
	logic [DUTY_SUM_W-1:0] sum;

	always_comb begin
		direct = (pending == centre) || (pending < centre && applied > centre)
			|| (pending > centre && applied < centre);
		sum = DUTY_WT_NEW * DUTY_SUM_W'(pending) + DUTY_WT_OLD * DUTY_SUM_W'(applied);
		duty = direct ? pending : sum[DUTY_SUM_W-1:BLEND_SHIFT];
	end

endmodule
